>>> src/assert_macros.svh
// Assertion macros for the RTL; dpq_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every clock edge outside reset.
`define DPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define DPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

>>> src/dpq_pkg.sv
// Shared constants and types of the double-ended priority queue.
package dpq_pkg;
  localparam int unsigned Depth = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned NodeW = AddrW - 1;
  localparam int unsigned CntW  = AddrW + 1;

  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_REMOVE_MIN = 2'd1;
  localparam logic [1:0] CMD_REMOVE_MAX = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REM_MIN,
    OP_REM_MAX,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] value;
  } item_t;
endpackage

>>> src/double_ended_priority_queue_core.sv
// Top level: interval-heap double-ended priority queue with capacity register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid_i/in_ready_o| command_i, value_i
//  out      | out_valid_o/ready_i  | removed_value_o, status_o, occupancy_o
//  cfg      | cfg_valid_i/ready_o  | cfg_data_i (capacity limit)
//
// Removals and inserts both sift level by level through the heap in the engine;
// each command is registered in the front queue before it reaches the engine.
// One memory read and one write per cycle bound each sift step.
// Reset empties the queue and sets the limit to 64; no clearing pass.
// Two commands queue ahead of the engine; a stalled output holds the engine.
module double_ended_priority_queue_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       command_i,
  input  logic signed [dpq_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dpq_pkg::DataW-1:0] removed_value_o,
  output logic [1:0]                       status_o,
  output logic [dpq_pkg::CntW-1:0]         occupancy_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dpq_pkg::CntW-1:0]         cfg_data_i
);
  import dpq_pkg::*;

  logic [CntW-1:0] cap_q, limit;
  item_t           item;
  logic            item_valid, item_ready;

  assign cfg_ready_o = 1'b1;
  assign limit = (cap_q > CntW'(Depth)) ? CntW'(Depth) : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(Depth);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  dpq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  dpq_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_ready_o    (item_ready),
    .item_i          (item),
    .limit_i         (limit),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );
endmodule

>>> src/dpq_front.sv
// Front end: command decode and a two-entry queue toward the heap engine.
module dpq_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic signed [dpq_pkg::DataW-1:0] value_i,
  output logic                            item_valid_o,
  input  logic                            item_ready_i,
  output dpq_pkg::item_t                  item_o
);
  import dpq_pkg::*;

  item_t      buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  item_t      dec;
  logic       push, pop;

  always_comb begin
    dec.value = value_i;
    case (command_i)
      CMD_INSERT:     dec.op = OP_INSERT;
      CMD_REMOVE_MIN: dec.op = OP_REM_MIN;
      CMD_REMOVE_MAX: dec.op = OP_REM_MAX;
      default:        dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o   = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = buf_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end
endmodule

>>> src/dpq_back.sv
// Back end: interval heap store, sift sequencer and result register.
`include "assert_macros.svh"
module dpq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  dpq_pkg::item_t                    item_i,
  input  logic [dpq_pkg::CntW-1:0]          limit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [dpq_pkg::DataW-1:0]  removed_value_o,
  output logic [1:0]                        status_o,
  output logic [dpq_pkg::CntW-1:0]          occupancy_o
);
  import dpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CMP, S_RISE_RD, S_RISE_CMP, S_RM_RD1, S_RM_X,
    S_SK_RD1, S_SK_RD2, S_SK_CMP, S_SK_MOVE, S_SK_PART, S_OUT
  } state_e;

  logic signed [DataW-1:0] mem [Depth];
  logic signed [DataW-1:0] rd_data_q;
  logic                    rd_en, wr_en;
  logic [AddrW-1:0]        rd_addr, wr_addr;
  logic signed [DataW-1:0] wr_data;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [DataW-1:0] x_q, x_d, res_q, res_d, b1_q, b1_d, bv_q, bv_d;
  logic [1:0]              st_q, st_d;
  logic                    min_q, min_d, odd_q, odd_d, has2_q, has2_d;
  logic [AddrW-1:0]        hole_q, hole_d;
  logic [NodeW-1:0]        nd_q, nd_d, i_q, i_d, best_q, best_d;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_val_q;
  logic [1:0]              out_st_q;
  logic [CntW-1:0]         out_occ_q;

  logic [NodeW-1:0]        par, cnt_nd;
  logic [AddrW-1:0]        k1;
  logic [AddrW:0]          k2;
  logic                    k1_ok, k2_ok, k1_hm, k2_hm, best_hm, pick2, move, load;
  logic signed [DataW-1:0] bv_sel;

  assign par    = nd_q - NodeW'(1);
  assign cnt_nd = cnt_q[AddrW-1:1];
  assign k1     = {i_q, 1'b1};
  assign k2     = {1'b0, i_q, 1'b0} + (AddrW+1)'(2);
  assign k1_ok  = ({1'b0, k1, 1'b0} < {1'b0, cnt_q});
  assign k2_ok  = ({k2, 1'b0} < {1'b0, cnt_q});
  assign k1_hm  = ({1'b0, k1, 1'b1} < {1'b0, cnt_q});
  assign k2_hm  = ({k2, 1'b1} < {1'b0, cnt_q});
  assign best_hm = ({1'b0, best_q, 1'b1} < cnt_q);
  assign pick2  = has2_q && (min_q ? (rd_data_q < b1_q) : (rd_data_q > b1_q));
  assign bv_sel = pick2 ? rd_data_q : b1_q;
  assign move   = min_q ? (x_q > bv_sel) : (x_q < bv_sel);
  assign load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign item_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  x_d = x_q;  res_d = res_q;  b1_d = b1_q;  bv_d = bv_q;
    st_d = st_q;  min_d = min_q;  odd_d = odd_q;  has2_d = has2_q;
    hole_d = hole_q;  nd_d = nd_q;  i_d = i_q;  best_d = best_q;
    rd_en = 1'b0;  rd_addr = '0;
    wr_en = 1'b0;  wr_addr = '0;  wr_data = x_q;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          res_d = '0;
          st_d  = ST_DONE;
          x_d   = item_i.value;
          case (item_i.op)
            OP_INSERT: begin
              if (cnt_q >= limit_i || cnt_q >= CntW'(Depth)) begin
                st_d    = ST_FULL;
                state_d = S_OUT;
              end else begin
                cnt_d = cnt_q + CntW'(1);
                odd_d = cnt_q[0];
                nd_d  = cnt_nd;
                if (cnt_q[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = {cnt_nd, 1'b0};
                  state_d = S_INS_CMP;
                end else if (cnt_nd == '0) begin
                  hole_d  = cnt_q[AddrW-1:0];
                  min_d   = 1'b0;
                  state_d = S_RISE_RD;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = {(cnt_nd - NodeW'(1)) >> 1, 1'b1};
                  state_d = S_INS_CMP;
                end
              end
            end
            OP_REM_MIN, OP_REM_MAX: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_OUT;
              end else begin
                min_d   = (item_i.op == OP_REM_MIN);
                cnt_d   = cnt_q - CntW'(1);
                rd_en   = 1'b1;
                rd_addr = {{(AddrW-1){1'b0}},
                           (item_i.op == OP_REM_MIN) && (cnt_q != CntW'(1))};
                state_d = S_RM_RD1;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_INS_CMP: begin
        hole_d = {nd_q, 1'b0};
        if (odd_q) begin
          if (x_q > rd_data_q) begin
            wr_en   = 1'b1;
            wr_addr = {nd_q, 1'b1};
            wr_data = rd_data_q;
            min_d   = 1'b0;
          end else begin
            hole_d = {nd_q, 1'b1};
            min_d  = 1'b1;
          end
        end else begin
          min_d = (x_q < rd_data_q);
        end
        state_d = S_RISE_RD;
      end
      S_RISE_RD: begin
        if (nd_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = hole_q;
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {par >> 1, min_q};
          state_d = S_RISE_CMP;
        end
      end
      S_RISE_CMP: begin
        wr_en   = 1'b1;
        wr_addr = hole_q;
        if (min_q ? (x_q < rd_data_q) : (x_q > rd_data_q)) begin
          wr_data = rd_data_q;
          hole_d  = {par >> 1, min_q};
          nd_d    = par >> 1;
          state_d = S_RISE_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RM_RD1: begin
        res_d = rd_data_q;
        if (cnt_q == '0 || (cnt_q == CntW'(1) && min_q)) begin
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q[AddrW-1:0];
          state_d = S_RM_X;
        end
      end
      S_RM_X: begin
        x_d = rd_data_q;
        i_d = '0;
        if (cnt_q == CntW'(1)) begin
          // two elements before: the survivor becomes the max side of the root
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = rd_data_q;
          state_d = S_OUT;
        end else begin
          state_d = S_SK_RD1;
        end
      end
      S_SK_RD1: begin
        if (!k1_ok) begin
          wr_en   = 1'b1;
          wr_addr = {i_q, min_q};
          state_d = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {k1[NodeW-1:0], min_q && k1_hm};
          state_d = S_SK_RD2;
        end
      end
      S_SK_RD2: begin
        b1_d   = rd_data_q;
        has2_d = k2_ok;
        if (k2_ok) begin
          rd_en   = 1'b1;
          rd_addr = {k2[NodeW-1:0], min_q && k2_hm};
        end
        state_d = S_SK_CMP;
      end
      S_SK_CMP: begin
        best_d = pick2 ? k2[NodeW-1:0] : k1[NodeW-1:0];
        bv_d   = bv_sel;
        if (move) begin
          state_d = S_SK_MOVE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = {i_q, min_q};
          state_d = S_OUT;
        end
      end
      S_SK_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = {i_q, min_q};
        wr_data = bv_q;
        rd_en   = 1'b1;
        rd_addr = {best_q, ~min_q};
        state_d = S_SK_PART;
      end
      S_SK_PART: begin
        i_d     = best_q;
        state_d = S_SK_RD1;
        if (min_q) begin
          if (!best_hm) begin
            wr_en   = 1'b1;
            wr_addr = {best_q, 1'b0};
            state_d = S_OUT;
          end else if (x_q > rd_data_q) begin
            wr_en   = 1'b1;
            wr_addr = {best_q, 1'b0};
            x_d     = rd_data_q;
          end
        end else if (best_hm && x_q < rd_data_q) begin
          wr_en   = 1'b1;
          wr_addr = {best_q, 1'b1};
          x_d     = rd_data_q;
        end
      end
      S_OUT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  res_q <= res_d;  b1_q <= b1_d;  bv_q <= bv_d;
    min_q <= min_d;  odd_q <= odd_d;  has2_q <= has2_d;
    hole_q <= hole_d;  nd_q <= nd_d;  i_q <= i_d;  best_q <= best_d;
    st_q <= st_d;
    if (load) begin
      out_val_q <= res_q;
      out_st_q  <= st_q;
      out_occ_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_val_q;
  assign status_o        = out_st_q;
  assign occupancy_o     = out_occ_q;

  `DPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(Depth), "element count above depth")
  `DPQ_ASSERT(a_cnt_step, 1'b1 |=> (cnt_q == $past(cnt_q)) ||
    (cnt_q == $past(cnt_q) + CntW'(1)) || (cnt_q + CntW'(1) == $past(cnt_q)),
    "element count moved by more than one")
  `DPQ_ASSERT(a_refused_keeps, (load && st_q != ST_DONE) |-> (res_q == '0),
    "refused command carries a value")
endmodule
